// ===== rtl/core/sms_deliver_pdu_to_text_assert.svh =====
// assertion macros for the sms record to text decoder
// used by the modules that carry concurrent checks; needs clk and rst_n in scope
`ifndef SMS_DELIVER_PDU_TO_TEXT_ASSERT_SVH
`define SMS_DELIVER_PDU_TO_TEXT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define SDPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdpt assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdpt assertion failed");

`endif

// ===== rtl/core/sdpt_pkg.sv =====
// types, codes and helper functions for the sms record to text decoder
// no dependencies
package sdpt_pkg;

  localparam int MaxRes   = 10;
  localparam int SlotW    = 11;
  localparam int CntW     = 4;
  localparam int FifoDepthDef = 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [7:0] C_MARK  = 8'h11;
  localparam logic [7:0] C_UDHI  = 8'h40;
  localparam logic [7:0] C_INTL  = 8'h91;
  localparam logic [7:0] C_ALPHA = 8'hD0;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_CR    = 8'h0D;
  localparam logic [7:0] C_AT    = 8'h40;
  localparam logic [7:0] C_DOL   = 8'h24;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_PLUS  = 8'h2B;
  localparam logic [7:0] C_DASH  = 8'h2D;
  localparam logic [7:0] C_COLON = 8'h3A;
  localparam logic [7:0] C_SLASH = 8'h2F;
  localparam logic [7:0] C_QUES  = 8'h3F;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] DCS_UCS2 = 8'h08;
  localparam logic [15:0] UCS_LO  = 16'h0410;
  localparam logic [15:0] UCS_HI  = 16'h0450;
  localparam logic [15:0] UCS_OFS = 16'h0350;

  typedef enum logic [15:0] {
    PH_MARK1   = 16'h0001,
    PH_MARK2   = 16'h0002,
    PH_FLAG    = 16'h0004,
    PH_SCALEN  = 16'h0008,
    PH_SCASKIP = 16'h0010,
    PH_FIRST   = 16'h0020,
    PH_ALEN    = 16'h0040,
    PH_ATYPE   = 16'h0080,
    PH_ADDR    = 16'h0100,
    PH_PID     = 16'h0200,
    PH_DCS     = 16'h0400,
    PH_TIME    = 16'h0800,
    PH_TZ      = 16'h1000,
    PH_UDL     = 16'h2000,
    PH_UD      = 16'h4000,
    PH_DRAIN   = 16'h8000
  } phase_t;

  // slot: {status, line_end, char}
  typedef struct packed {
    logic [CntW-1:0]                 cnt;
    logic [MaxRes-1:0][SlotW-1:0]    slot;
  } cmd_t;

  function automatic cmd_t put(cmd_t c, logic [7:0] ch, logic e, logic [1:0] st);
    cmd_t r;
    r = c;
    if (c.cnt < CntW'(MaxRes)) begin
      r.slot[c.cnt] = {st, e, ch};
      r.cnt = c.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic cmd_t put_dec(cmd_t c, logic [7:0] v);
    cmd_t r;
    logic [1:0]  h;
    logic [7:0]  rem;
    logic [15:0] p;
    logic [3:0]  t;
    logic [3:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem = v - 8'(h) * 8'd100;
    p = {8'b0, rem} * 16'd205;
    t = p[14:11];
    o = 4'(rem - 8'(t) * 8'd10);
    r = c;
    if (v >= 8'd100) r = put(r, C_ZERO + 8'(h), 1'b0, ST_OK);
    if (v >= 8'd10) r = put(r, C_ZERO + 8'(t), 1'b0, ST_OK);
    r = put(r, C_ZERO + 8'(o), 1'b0, ST_OK);
    return r;
  endfunction

  function automatic logic [8:0] div7(logic [11:0] x);
    logic [25:0] p;
    p = {14'b0, x} * 26'd2341;
    return p[22:14];
  endfunction

  function automatic logic [7:0] sept_char(logic [6:0] s);
    if (s == 7'd0) return C_AT;
    if (s == 7'd2) return C_DOL;
    return {1'b0, s};
  endfunction

endpackage

// ===== rtl/core/sdpt_front.sv =====
// front end: parses one record byte per beat and builds the list of result characters
// depends on sdpt_pkg
module sdpt_front import sdpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_hs,
  input  logic [7:0] byte_i,
  input  logic       fe_i,
  output logic       push,
  output cmd_t       cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] field_count_r, field_count_nxt;
  logic [7:0] addr_nibbles_r, addr_nibbles_nxt;
  logic       addr_alpha_r, addr_alpha_nxt;
  logic [7:0] coding_r, coding_nxt;
  logic       has_header_r, has_header_nxt;
  logic [7:0] header_len_r, header_len_nxt;
  logic [1:0] concat_kind_r, concat_kind_nxt;
  logic [7:0] concat_total_r, concat_total_nxt;
  logic [7:0] text_left_r, text_left_nxt;
  logic [7:0] septet_skip_r, septet_skip_nxt;
  logic [7:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] ucs_high_r, ucs_high_nxt;

  always_comb begin
    cmd_t        c;
    logic [7:0]  b;
    logic [14:0] acc;
    logic [4:0]  cnt;
    logic [7:0]  sc;
    logic [7:0]  idx;
    logic [8:0]  h1;
    logic [8:0]  k;
    logic [15:0] u;
    logic [7:0]  tpos;
    logic [7:0]  sep;
    logic        hdr_byte;
    b = byte_i;
    c = '0;
    acc = '0;
    cnt = '0;
    sc = '0;
    idx = '0;
    h1 = '0;
    k = '0;
    u = '0;
    tpos = '0;
    sep = '0;
    hdr_byte = 1'b0;
    phase_nxt = phase_r;
    field_count_nxt = field_count_r;
    addr_nibbles_nxt = addr_nibbles_r;
    addr_alpha_nxt = addr_alpha_r;
    coding_nxt = coding_r;
    has_header_nxt = has_header_r;
    header_len_nxt = header_len_r;
    concat_kind_nxt = concat_kind_r;
    concat_total_nxt = concat_total_r;
    text_left_nxt = text_left_r;
    septet_skip_nxt = septet_skip_r;
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt = bit_count_r;
    ucs_high_nxt = ucs_high_r;
    if (in_hs) begin
      unique case (phase_r)
        PH_MARK1: begin
          if (b != C_MARK) begin
            c = put(c, 8'd0, 1'b1, ST_BAD); phase_nxt = PH_DRAIN;
          end else phase_nxt = PH_MARK2;
        end
        PH_MARK2: begin
          if (b != C_MARK) begin
            c = put(c, 8'd0, 1'b1, ST_BAD); phase_nxt = PH_DRAIN;
          end else phase_nxt = PH_FLAG;
        end
        PH_FLAG: begin
          if (b == 8'd0) begin
            c = put(c, 8'd0, 1'b1, ST_BAD); phase_nxt = PH_DRAIN;
          end else phase_nxt = PH_SCALEN;
        end
        PH_SCALEN: begin
          field_count_nxt = b;
          phase_nxt = (b != 8'd0) ? PH_SCASKIP : PH_FIRST;
        end
        PH_SCASKIP: begin
          field_count_nxt = field_count_r - 1'b1;
          if (field_count_nxt == 8'd0) phase_nxt = PH_FIRST;
        end
        PH_FIRST: begin
          if (b[1:0] != 2'b00) begin
            c = put(c, 8'd0, 1'b1, ST_BAD); phase_nxt = PH_DRAIN;
          end else begin
            has_header_nxt = (b & C_UDHI) != 8'd0;
            phase_nxt = PH_ALEN;
          end
        end
        PH_ALEN: begin
          addr_nibbles_nxt = b;
          phase_nxt = PH_ATYPE;
        end
        PH_ATYPE: begin
          if (b == C_INTL) c = put(c, C_PLUS, 1'b0, ST_OK);
          addr_alpha_nxt = (b & C_ALPHA) == C_ALPHA;
          field_count_nxt = 8'(({1'b0, addr_nibbles_r} + 9'd1) >> 1);
          if (addr_alpha_nxt) addr_nibbles_nxt = 8'(div7({2'b0, addr_nibbles_r, 2'b0}));
          bit_buffer_nxt = '0;
          bit_count_nxt = '0;
          if (field_count_nxt == 8'd0) begin
            c = put(c, C_SP, 1'b0, ST_OK);
            phase_nxt = PH_PID;
          end else phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          if (addr_alpha_r) begin
            acc = {7'b0, bit_buffer_r} | ({7'b0, b} << bit_count_r[2:0]);
            cnt = {1'b0, bit_count_r} + 5'd8;
            for (int i = 0; i < 2; i++) begin
              if (cnt >= 5'd7 && addr_nibbles_nxt != 8'd0) begin
                c = put(c, sept_char(acc[6:0]), 1'b0, ST_OK);
                acc = acc >> 7;
                cnt = cnt - 5'd7;
                addr_nibbles_nxt = addr_nibbles_nxt - 1'b1;
              end
            end
            if (addr_nibbles_nxt == 8'd0) begin
              acc = '0; cnt = '0;
            end
            bit_buffer_nxt = {1'b0, acc[6:0]};
            bit_count_nxt = cnt[3:0];
          end else begin
            if (addr_nibbles_nxt != 8'd0) begin
              c = put(c, C_ZERO + {4'b0, b[3:0]}, 1'b0, ST_OK);
              addr_nibbles_nxt = addr_nibbles_nxt - 1'b1;
            end
            if (addr_nibbles_nxt != 8'd0) begin
              c = put(c, C_ZERO + {4'b0, b[7:4]}, 1'b0, ST_OK);
              addr_nibbles_nxt = addr_nibbles_nxt - 1'b1;
            end
          end
          field_count_nxt = field_count_r - 1'b1;
          if (field_count_nxt == 8'd0) begin
            c = put(c, C_SP, 1'b0, ST_OK);
            phase_nxt = PH_PID;
          end
        end
        PH_PID: phase_nxt = PH_DCS;
        PH_DCS: begin
          coding_nxt = b;
          field_count_nxt = '0;
          phase_nxt = PH_TIME;
        end
        PH_TIME: begin
          if (field_count_r < 8'd2) sep = C_DASH;
          else if (field_count_r == 8'd3 || field_count_r == 8'd4) sep = C_COLON;
          else sep = C_SP;
          c = put(c, C_ZERO + {4'b0, b[3:0]}, 1'b0, ST_OK);
          c = put(c, C_ZERO + {4'b0, b[7:4]}, 1'b0, ST_OK);
          c = put(c, sep, 1'b0, ST_OK);
          field_count_nxt = field_count_r + 1'b1;
          if (field_count_nxt >= 8'd6) phase_nxt = PH_TZ;
        end
        PH_TZ: phase_nxt = PH_UDL;
        PH_UDL: begin
          text_left_nxt = b;
          septet_skip_nxt = '0;
          concat_kind_nxt = '0;
          concat_total_nxt = '0;
          header_len_nxt = '0;
          bit_buffer_nxt = '0;
          bit_count_nxt = '0;
          ucs_high_nxt = '0;
          field_count_nxt = '0;
          if (coding_r == DCS_UCS2 && has_header_r) begin
            phase_nxt = PH_UD;
          end else begin
            if (coding_r == DCS_UCS2) text_left_nxt = b >> 1;
            if (text_left_nxt == 8'd0) begin
              c = put(c, C_CR, 1'b1, ST_OK); phase_nxt = PH_DRAIN;
            end else phase_nxt = PH_UD;
          end
        end
        PH_UD: begin
          idx = field_count_r;
          hdr_byte = has_header_r && idx == 8'd0;
          if (has_header_r) begin
            if (idx == 8'd0) begin
              h1 = {1'b0, b} + 9'd1;
              header_len_nxt = b;
              if (coding_r == DCS_UCS2) begin
                text_left_nxt = ({1'b0, text_left_r} >= h1)
                              ? 8'(({1'b0, text_left_r} - h1) >> 1) : 8'd0;
                septet_skip_nxt = b;
              end else begin
                k = div7({h1, 3'b0} + 12'd6);
                septet_skip_nxt = k[8] ? 8'hFF : k[7:0];
              end
            end else if (idx <= header_len_r) begin
              if (idx == 8'd1) begin
                concat_kind_nxt = (b == 8'd0) ? 2'd1 : ((b == 8'd8) ? 2'd2 : 2'd0);
              end else if (concat_kind_r != 2'd0) begin
                tpos = (concat_kind_r == 2'd1) ? 8'd4 : 8'd5;
                if (idx == tpos) begin
                  concat_total_nxt = b;
                end else if (idx == tpos + 8'd1) begin
                  c = put_dec(c, b);
                  c = put(c, C_SLASH, 1'b0, ST_OK);
                  c = put_dec(c, concat_total_r);
                  c = put(c, C_SP, 1'b0, ST_OK);
                end
              end
            end
          end
          if (field_count_r != 8'hFF) field_count_nxt = field_count_r + 1'b1;
          if (coding_r == DCS_UCS2) begin
            if (hdr_byte) begin
              sc = '0;
            end else if (septet_skip_nxt != 8'd0) begin
              septet_skip_nxt = septet_skip_nxt - 1'b1;
            end else if (text_left_nxt != 8'd0) begin
              if (bit_count_r == 4'd0) begin
                ucs_high_nxt = b;
                bit_count_nxt = 4'd1;
              end else begin
                u = {ucs_high_r, b};
                bit_count_nxt = 4'd0;
                if (u >= UCS_LO && u < UCS_HI) u = u - UCS_OFS;
                if (u == 16'd0) sc = C_QUES;
                else if (u == 16'(C_LF) || u == 16'(C_CR)) sc = C_SP;
                else sc = u[7:0];
                c = put(c, sc, 1'b0, ST_OK);
                text_left_nxt = text_left_nxt - 1'b1;
              end
            end
            if (septet_skip_nxt == 8'd0 && text_left_nxt == 8'd0) begin
              c = put(c, C_CR, 1'b1, ST_OK); phase_nxt = PH_DRAIN;
            end
          end else begin
            acc = {7'b0, bit_buffer_r} | ({7'b0, b} << bit_count_r[2:0]);
            cnt = {1'b0, bit_count_r} + 5'd8;
            for (int i = 0; i < 2; i++) begin
              if (cnt >= 5'd7 && text_left_nxt != 8'd0) begin
                sc = sept_char(acc[6:0]);
                if (sc == C_LF || sc == C_CR) sc = C_SP;
                if (septet_skip_nxt != 8'd0) septet_skip_nxt = septet_skip_nxt - 1'b1;
                else c = put(c, sc, 1'b0, ST_OK);
                text_left_nxt = text_left_nxt - 1'b1;
                acc = acc >> 7;
                cnt = cnt - 5'd7;
              end
            end
            if (text_left_nxt == 8'd0) begin
              bit_buffer_nxt = '0;
              bit_count_nxt = '0;
              c = put(c, C_CR, 1'b1, ST_OK); phase_nxt = PH_DRAIN;
            end else begin
              bit_buffer_nxt = {1'b0, acc[6:0]};
              bit_count_nxt = cnt[3:0];
            end
          end
        end
        PH_DRAIN: phase_nxt = PH_DRAIN;
        default: phase_nxt = PH_MARK1;
      endcase
      if (fe_i) begin
        if (phase_nxt != PH_DRAIN) c = put(c, 8'd0, 1'b1, ST_TRUNC);
        phase_nxt = PH_MARK1;
      end
    end
    cmd = c;
    push = in_hs && c.cnt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARK1;
      field_count_r <= '0;
      addr_nibbles_r <= '0;
      addr_alpha_r <= 1'b0;
      coding_r <= '0;
      has_header_r <= 1'b0;
      header_len_r <= '0;
      concat_kind_r <= '0;
      concat_total_r <= '0;
      text_left_r <= '0;
      septet_skip_r <= '0;
      bit_buffer_r <= '0;
      bit_count_r <= '0;
      ucs_high_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      field_count_r <= field_count_nxt;
      addr_nibbles_r <= addr_nibbles_nxt;
      addr_alpha_r <= addr_alpha_nxt;
      coding_r <= coding_nxt;
      has_header_r <= has_header_nxt;
      header_len_r <= header_len_nxt;
      concat_kind_r <= concat_kind_nxt;
      concat_total_r <= concat_total_nxt;
      text_left_r <= text_left_nxt;
      septet_skip_r <= septet_skip_nxt;
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r <= bit_count_nxt;
      ucs_high_r <= ucs_high_nxt;
    end
  end

endmodule

// ===== rtl/core/sdpt_fifo.sv =====
// short command queue between front and back end
// depends on sdpt_pkg
module sdpt_fifo import sdpt_pkg::*; #(
  parameter int Depth = FifoDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_r [Depth];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full  = cnt_r == (AW+1)'(Depth);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (pop && !empty) begin
      rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/sdpt_back.sv =====
// back end: holds one command and sends its characters one beat at a time
// depends on sdpt_pkg and the assertion macro header
`include "sms_deliver_pdu_to_text_assert.svh"
module sdpt_back import sdpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  cmd_t            cur_r;
  logic            vld_r, vld_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic            last;
  logic            load;

  assign last = idx_r == cur_r.cnt - 1'b1;
  assign load = !vld_r || (out_tready && last);
  assign q_pop = load && !q_empty;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = !q_empty;
      idx_nxt = '0;
    end else if (out_tready) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {6'b0, cur_r.slot[idx_r][SlotW-1 -: 2], cur_r.slot[idx_r][7:0]};
  assign out_tlast  = cur_r.slot[idx_r][8];

  `SDPT_ASSERT_IMP(a_idx_range, vld_r, idx_r < cur_r.cnt)
  `SDPT_ASSERT_IMP(a_end_is_last, vld_r && out_tlast, last)
  `SDPT_ASSERT_NEXT(a_stall_holds, vld_r && !out_tready, vld_r && $stable(idx_r))

endmodule

// ===== rtl/core/sms_deliver_pdu_to_text.sv =====
// top level of the sms record to text decoder
// depends on sdpt_pkg, sdpt_front, sdpt_fifo and sdpt_back
//
// Each accepted record byte is parsed combinationally by the front end and its
// result characters (up to ten) go as one entry into a two-entry queue; the
// back end sends them one beat per cycle while out_tready is high. A byte
// produces up to three characters for a timestamp byte and more for a
// concatenation mark, and the output port paces intake once the queue is
// full. There is no clearing pass after reset.
module sms_deliver_pdu_to_text import sdpt_pkg::*; #(
  parameter int FifoDepth = FifoDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pdu_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_char[7:0], status[9:8], zero fill
  output logic        out_tlast   // line_end
);

  logic push, full, pop, empty;
  cmd_t cmd, head;

  assign in_tready = !full;

  sdpt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_hs(in_tvalid && in_tready),
    .byte_i(in_tdata), .fe_i(in_tlast), .push(push), .cmd(cmd)
  );

  sdpt_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(cmd), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  sdpt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

endmodule
